// ===== rtl/core/bakos_pkg.sv =====
`default_nettype none

package bakos_pkg;

  localparam int OP_W      = 2;
  localparam int INDEX_W   = 11;
  localparam int RANK_W    = 11;
  localparam int POS_W     = 11;
  localparam int LENGTH_W  = 11;
  localparam int IN_DATA_W = 24;
  localparam int OUT_DATA_W = 16;

  localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
  localparam logic [OP_W-1:0] OP_TOGGLE = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

  localparam logic [LENGTH_W-1:0] ACTIVE_LENGTH_RESET = 11'd1024;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/bakos_ram.sv =====
`default_nettype none

module bakos_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic                                       re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bakos_ctrl.sv =====
`default_nettype none

module bakos_ctrl
  import bakos_pkg::*;
#(
  parameter int SIZE = 1024
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     in_valid,
  output logic                                          in_ready,
  input  wire logic [OP_W-1:0]                          in_op,
  input  wire logic [INDEX_W-1:0]                       in_index,
  input  wire logic                                     in_bit,
  input  wire logic [RANK_W-1:0]                        in_rank,
  input  wire logic [LENGTH_W-1:0]                      active_length,
  output logic                                          res_valid,
  input  wire logic                                     res_ready,
  output res_t                                          res,
  output logic                                          bit_we,
  output logic [((SIZE > 1) ? $clog2(SIZE) : 1)-1:0]    bit_waddr,
  output logic [0:0]                                    bit_wdata,
  output logic                                          bit_re,
  output logic [((SIZE > 1) ? $clog2(SIZE) : 1)-1:0]    bit_raddr,
  input  wire logic [0:0]                               bit_rdata,
  output logic                                          tree_we,
  output logic [((SIZE > 1) ? $clog2(SIZE) : 1)-1:0]    tree_waddr,
  output logic [$clog2(SIZE+1)-1:0]                     tree_wdata,
  output logic                                          tree_re,
  output logic [((SIZE > 1) ? $clog2(SIZE) : 1)-1:0]    tree_raddr,
  input  wire logic [$clog2(SIZE+1)-1:0]                tree_rdata
);

  localparam int AW = (SIZE > 1) ? $clog2(SIZE) : 1;
  localparam int PW = $clog2(SIZE + 1);
  localparam int CW = PW;
  localparam int VW = (PW + 1 > 12) ? PW + 1 : 12;
  localparam int RW = (CW > RANK_W) ? CW : RANK_W;
  localparam int TOP_LOG = PW - 1;

  localparam logic [VW-1:0] SIZE_V = VW'(SIZE);
  localparam logic [VW-1:0] TOP_V  = VW'(1) << TOP_LOG;
  localparam logic [AW-1:0] CLR_LAST = AW'(SIZE - 1);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_BIT    = 3'd2;
  localparam logic [2:0] S_ADJ    = 3'd3;
  localparam logic [2:0] S_FIND   = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;

  logic [2:0]    state;
  logic [AW-1:0] clr;

  logic [OP_W-1:0] op_r;
  logic [VW-1:0]   idx_r;
  logic            bit_r;

  // tree update walk
  logic [VW-1:0] upos;
  logic          up;
  logic          wpend;
  logic [AW-1:0] adj_waddr;

  // tree descent
  logic [VW-1:0] fpos;
  logic [VW-1:0] fstep;
  logic [VW-1:0] fnxt;
  logic [RW-1:0] frem;
  logic          fwait;

  logic [VW-1:0] lim;
  logic [VW-1:0] idx_v;
  logic          in_range;
  logic          accept;
  logic          old_bit;
  logic          new_bit;
  logic [VW-1:0] upos_low;
  logic [VW-1:0] nxt;
  logic [VW-1:0] hit;
  logic [RW-1:0] cnt_ext;

  assign lim      = (VW'(active_length) > SIZE_V) ? SIZE_V : VW'(active_length);
  assign idx_v    = VW'(in_index);
  assign in_range = (idx_v != '0) && (idx_v <= lim);
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign old_bit  = bit_rdata[0];
  assign new_bit  = (op_r == OP_WRITE) ? bit_r : ~old_bit;
  assign upos_low = upos & (~upos + VW'(1));
  assign nxt      = fpos + fstep;
  assign hit      = fpos + VW'(1);
  assign cnt_ext  = RW'(tree_rdata);
  assign res_valid = (state == S_RESULT);

  always_comb begin
    bit_we     = 1'b0;
    bit_waddr  = AW'(idx_r - VW'(1));
    bit_wdata  = new_bit;
    bit_re     = 1'b0;
    bit_raddr  = AW'(idx_v - VW'(1));
    tree_we    = 1'b0;
    tree_waddr = adj_waddr;
    tree_wdata = up ? (tree_rdata + CW'(1)) : (tree_rdata - CW'(1));
    tree_re    = 1'b0;
    tree_raddr = AW'(upos - VW'(1));
    unique case (state)
      S_CLEAR: begin
        bit_we     = 1'b1;
        bit_waddr  = clr;
        bit_wdata  = 1'b0;
        tree_we    = 1'b1;
        tree_waddr = clr;
        tree_wdata = '0;
      end
      S_IDLE: begin
        bit_re = accept && (in_op == OP_WRITE || in_op == OP_TOGGLE) && in_range;
      end
      S_BIT: begin
        bit_we = (new_bit != old_bit);
      end
      S_ADJ: begin
        tree_we = wpend;
        tree_re = (upos <= SIZE_V);
      end
      S_FIND: begin
        tree_raddr = AW'(nxt - VW'(1));
        tree_re    = !fwait && (fstep != '0) && (nxt <= SIZE_V);
      end
      S_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
      wpend <= 1'b0;
      fwait <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr <= clr + AW'(1);
          if (clr == CLR_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          op_r  <= in_op;
          idx_r <= idx_v;
          bit_r <= in_bit;
          fpos  <= '0;
          fstep <= TOP_V;
          frem  <= RW'(in_rank);
          fwait <= 1'b0;
          wpend <= 1'b0;
          if (accept) begin
            if ((in_op == OP_WRITE || in_op == OP_TOGGLE) && in_range) begin
              state <= S_BIT;
            end else if (in_op == OP_FIND) begin
              if (in_rank == '0) begin
                res   <= '{found: 1'b0, position: '0};
                state <= S_RESULT;
              end else begin
                state <= S_FIND;
              end
            end
          end
        end
        S_BIT: begin
          upos <= idx_r;
          up   <= new_bit;
          state <= (new_bit != old_bit) ? S_ADJ : S_IDLE;
        end
        S_ADJ: begin
          // read of the next ancestor overlaps the write-back of the previous one
          if (upos <= SIZE_V) begin
            adj_waddr <= AW'(upos - VW'(1));
            wpend     <= 1'b1;
            upos      <= upos + upos_low;
          end else begin
            wpend <= 1'b0;
            state <= S_IDLE;
          end
        end
        S_FIND: begin
          if (fwait) begin
            if (cnt_ext < frem) begin
              fpos <= fnxt;
              frem <= frem - cnt_ext;
            end
            fstep <= fstep >> 1;
            fwait <= 1'b0;
          end else if (fstep == '0) begin
            res.found    <= (hit <= lim);
            res.position <= (hit <= lim) ? hit[POS_W-1:0] : '0;
            state        <= S_RESULT;
          end else if (nxt <= SIZE_V) begin
            fnxt  <= nxt;
            fwait <= 1'b1;
          end else begin
            fstep <= fstep >> 1;
          end
        end
        S_RESULT: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bit_array_kth_one_select_top.sv =====
`default_nettype none

// write or toggle: the stored bit is read and checked first; if it changes, the update path
//   goes up one tree level per cycle plus a last write-back, else the item ends there
// find: each tree level on the descent that lies within the array waits on a read of the count
//   memory before it compares; the next input can be taken while the result waits in the
//   output register
// reset: synchronous; a clearing pass over every address zeroes both memories, input held off

module bit_array_kth_one_select_top
  import bakos_pkg::*;
#(
  parameter int SIZE = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // index[10:0], bit_value[11], rank[22:12]
  input  wire logic [OP_W-1:0]       s_axis_tuser,  // operation[1:0]
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // position[10:0]
  output logic [0:0]                 m_axis_tuser,  // found[0]
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [LENGTH_W-1:0]   cfg_data
);

  localparam int AW = (SIZE > 1) ? $clog2(SIZE) : 1;
  localparam int CW = $clog2(SIZE + 1);

  logic [LENGTH_W-1:0] active_length;
  logic                res_valid;
  logic                res_ready;
  res_t                res;
  res_t                out_res;

  logic          bit_we;
  logic [AW-1:0] bit_waddr;
  logic [0:0]    bit_wdata;
  logic          bit_re;
  logic [AW-1:0] bit_raddr;
  logic [0:0]    bit_rdata;
  logic          tree_we;
  logic [AW-1:0] tree_waddr;
  logic [CW-1:0] tree_wdata;
  logic          tree_re;
  logic [AW-1:0] tree_raddr;
  logic [CW-1:0] tree_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_length <= ACTIVE_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      active_length <= cfg_data;
    end
  end

  bakos_ctrl #(
    .SIZE(SIZE)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_op        (s_axis_tuser),
    .in_index     (s_axis_tdata[10:0]),
    .in_bit       (s_axis_tdata[11]),
    .in_rank      (s_axis_tdata[22:12]),
    .active_length(active_length),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .bit_we       (bit_we),
    .bit_waddr    (bit_waddr),
    .bit_wdata    (bit_wdata),
    .bit_re       (bit_re),
    .bit_raddr    (bit_raddr),
    .bit_rdata    (bit_rdata),
    .tree_we      (tree_we),
    .tree_waddr   (tree_waddr),
    .tree_wdata   (tree_wdata),
    .tree_re      (tree_re),
    .tree_raddr   (tree_raddr),
    .tree_rdata   (tree_rdata)
  );

  bakos_ram #(
    .WIDTH(1),
    .DEPTH(SIZE)
  ) u_bit_mem (
    .clk  (clk),
    .we   (bit_we),
    .waddr(bit_waddr),
    .wdata(bit_wdata),
    .re   (bit_re),
    .raddr(bit_raddr),
    .rdata(bit_rdata)
  );

  bakos_ram #(
    .WIDTH(CW),
    .DEPTH(SIZE)
  ) u_tree_mem (
    .clk  (clk),
    .we   (tree_we),
    .waddr(tree_waddr),
    .wdata(tree_wdata),
    .re   (tree_re),
    .raddr(tree_raddr),
    .rdata(tree_rdata)
  );

  // output register, refilled in the cycle it is drained
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = OUT_DATA_W'(out_res.position);
  assign m_axis_tuser = out_res.found;

`ifndef NO_ASSERTIONS
  a_miss_zero_pos: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[10:0] == '0)
    else $error("not-found result carries a nonzero position");

  a_hit_in_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |->
      m_axis_tdata[10:0] != '0 && m_axis_tdata[10:0] <= active_length)
    else $error("found position outside the active range");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready |=> m_axis_tvalid)
    else $error("result transfer into output register lost");
`endif

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`default_nettype none

module testbench;
  import bakos_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIZE = 1024;
  localparam int unsigned CYCLE_LIMIT = 500000;
  // longest quiet time after the last find: a write or toggle walks the tree
  localparam int DRAIN_CYCLES = 64;
  localparam int ITEMS_PER_PHASE = 160;
  localparam int DIR_ROWS = 24;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [INDEX_W-1:0] idx;
    logic               bv;
    logic [RANK_W-1:0]  rnk;
  } bit_op_t;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [INDEX_W-1:0] idx;
    logic               bv;
    logic [RANK_W-1:0]  rnk;
    bit                 typed;
    logic               want_found;
    logic [POS_W-1:0]   want_pos;
  } dir_row_t;

  typedef struct {
    logic [LENGTH_W-1:0] length;
    int unsigned         send_idle;
    int unsigned         recv_stall;
  } phase_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;  // index[10:0], bit_value[11], rank[22:12]
  logic [OP_W-1:0]       s_axis_tuser = '0;  // operation[1:0]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;       // position[10:0]
  logic [0:0]            m_axis_tuser;       // found[0]
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [LENGTH_W-1:0]   cfg_data = '0;

  bit                  stored_bits [1:SIZE];
  logic [LENGTH_W-1:0] active_len;
  res_t                pending_finds [$];
  int unsigned         mismatches = 0;
  int unsigned         cycles = 0;
  int unsigned         send_idle_pct = 0;
  int unsigned         recv_stall_pct = 0;

  dir_row_t directed [DIR_ROWS] = '{
    '{OP_FIND,   11'd0,    1'b0, 11'd1,    1'b1, 1'b0, 11'd0},     // empty after reset
    '{OP_FIND,   11'd0,    1'b0, 11'd0,    1'b1, 1'b0, 11'd0},
    '{OP_WRITE,  11'd1,    1'b1, 11'd0,    1'b0, 1'b0, 11'd0},
    '{OP_FIND,   11'd1,    1'b0, 11'd1,    1'b1, 1'b1, 11'd1},
    '{OP_FIND,   11'd1,    1'b1, 11'd0,    1'b1, 1'b0, 11'd0},     // rank zero with bits set
    '{OP_WRITE,  11'd1024, 1'b1, 11'd0,    1'b0, 1'b0, 11'd0},
    '{OP_FIND,   11'd0,    1'b0, 11'd2,    1'b1, 1'b1, 11'd1024},
    '{OP_FIND,   11'd0,    1'b0, 11'd3,    1'b1, 1'b0, 11'd0},     // rank past the last one
    '{OP_FIND,   11'd2047, 1'b1, 11'd2047, 1'b1, 1'b0, 11'd0},
    '{OP_WRITE,  11'd0,    1'b1, 11'd0,    1'b0, 1'b0, 11'd0},     // out of range, dropped
    '{OP_WRITE,  11'd1025, 1'b1, 11'd0,    1'b0, 1'b0, 11'd0},
    '{OP_WRITE,  11'd2047, 1'b1, 11'd2047, 1'b0, 1'b0, 11'd0},
    '{OP_FIND,   11'd0,    1'b0, 11'd3,    1'b1, 1'b0, 11'd0},
    '{OP_TOGGLE, 11'd1,    1'b0, 11'd0,    1'b0, 1'b0, 11'd0},
    '{OP_FIND,   11'd0,    1'b0, 11'd1,    1'b1, 1'b1, 11'd1024},
    '{OP_TOGGLE, 11'd512,  1'b1, 11'd5,    1'b0, 1'b0, 11'd0},
    '{OP_FIND,   11'd0,    1'b0, 11'd1,    1'b1, 1'b1, 11'd512},
    '{OP_UNUSED, 11'd5,    1'b1, 11'd1,    1'b0, 1'b0, 11'd0},     // spare opcode, dropped
    '{OP_WRITE,  11'd512,  1'b0, 11'd0,    1'b0, 1'b0, 11'd0},
    '{OP_WRITE,  11'd1024, 1'b0, 11'd0,    1'b0, 1'b0, 11'd0},
    '{OP_WRITE,  11'd700,  1'b1, 11'd2047, 1'b0, 1'b0, 11'd0},
    '{OP_FIND,   11'd0,    1'b0, 11'd1,    1'b1, 1'b1, 11'd700},
    '{OP_TOGGLE, 11'd0,    1'b1, 11'd0,    1'b0, 1'b0, 11'd0},
    '{OP_FIND,   11'd2047, 1'b1, 11'd1,    1'b0, 1'b0, 11'd0}
  };

  phase_t phases [8] = '{
    '{11'd1024, 0,  0},
    '{11'd1,    46, 0},
    '{11'd0,    0,  46},
    '{11'd2047, 31, 31},
    '{11'd37,   0,  0},
    '{11'd600,  46, 0},
    '{11'd1024, 0,  46},
    '{11'd513,  31, 31}
  };

  bit_array_kth_one_select_top #(.SIZE(SIZE)) DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // lengths above the array size behave as the full array
  function automatic int unsigned usable_limit();
    return (active_len > SIZE) ? SIZE : int'(active_len);
  endfunction

  function automatic int unsigned ones_in_range();
    int unsigned n;
    n = 0;
    for (int p = 1; p <= usable_limit(); p++) n += stored_bits[p];
    return n;
  endfunction

  // updates the bit array; returns 1 when the item produces a result
  function automatic bit predict_select(input bit_op_t it, output res_t res);
    int unsigned lim;
    int unsigned seen;
    lim = usable_limit();
    res = '0;
    case (it.op) inside
      OP_WRITE, OP_TOGGLE: begin
        if (it.idx >= 1 && it.idx <= lim)
          stored_bits[it.idx] = (it.op == OP_WRITE) ? it.bv : ~stored_bits[it.idx];
        return 1'b0;
      end
      OP_FIND: begin
        seen = 0;
        if (it.rnk != 0) begin
          for (int p = 1; p <= lim; p++) begin
            if (stored_bits[p]) begin
              seen++;
              if (seen == it.rnk) begin
                res.found = 1'b1;
                res.position = p[POS_W-1:0];
                break;
              end
            end
          end
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic note_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // drives one item and returns once its transfer has happened
  task automatic send_item(input bit_op_t it, output bit accepted_find, output res_t res);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.op;
    s_axis_tdata  <= {1'b0, it.rnk, it.bv, it.idx};
    do @(posedge clk); while (!s_axis_tready);
    accepted_find = predict_select(it, res);
  endtask

  task automatic write_length(input logic [LENGTH_W-1:0] len);
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    do @(posedge clk); while (!cfg_ready);
    active_len = len;
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    while (pending_finds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [INDEX_W-1:0] pick_index();
    if ($urandom_range(99) < 88 && usable_limit() > 0)
      return INDEX_W'($urandom_range(1, usable_limit()));
    return INDEX_W'($urandom_range(0, 2047));
  endfunction

  function automatic bit_op_t random_item();
    bit_op_t it;
    int unsigned pick;
    pick = $urandom_range(99);
    it.bv  = 1'($urandom_range(1));
    it.idx = INDEX_W'($urandom_range(0, 2047));
    it.rnk = RANK_W'($urandom_range(0, 2047));
    if (pick < 40) begin
      it.op  = OP_WRITE;
      it.idx = pick_index();
    end else if (pick < 58) begin
      it.op  = OP_TOGGLE;
      it.idx = pick_index();
    end else if (pick < 93) begin
      it.op = OP_FIND;
      if ($urandom_range(99) < 80) it.rnk = RANK_W'($urandom_range(0, ones_in_range() + 2));
    end else begin
      it.op = ($urandom_range(1) != 0) ? OP_UNUSED : OP_TOGGLE;
    end
    return it;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_finds.size() == 0) begin
        note_mismatch($sformatf("unexpected result found=%0b position=%0d",
                                m_axis_tuser[0], m_axis_tdata[POS_W-1:0]));
      end else begin
        want = pending_finds.pop_front();
        if (m_axis_tuser[0] !== want.found)
          note_mismatch($sformatf("found got %0b want %0b", m_axis_tuser[0], want.found));
        if (m_axis_tdata[POS_W-1:0] !== want.position)
          note_mismatch($sformatf("position got %0d want %0d",
                                  m_axis_tdata[POS_W-1:0], want.position));
      end
    end
  end

  initial begin
    bit_op_t it;
    res_t res;
    bit has_res;
    int unsigned done;
    foreach (stored_bits[p]) stored_bits[p] = 1'b0;
    active_len = ACTIVE_LENGTH_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[r]) begin
      it = '{directed[r].op, directed[r].idx, directed[r].bv, directed[r].rnk};
      send_item(it, has_res, res);
      if (has_res) begin
        if (directed[r].typed) pending_finds.push_back('{directed[r].want_found,
                                                         directed[r].want_pos});
        else pending_finds.push_back(res);
      end
    end

    foreach (phases[ph]) begin
      wait_quiet();
      write_length(phases[ph].length);
      send_idle_pct  = phases[ph].send_idle;
      recv_stall_pct = phases[ph].recv_stall;
      done = 0;
      while (done < ITEMS_PER_PHASE) begin
        it = random_item();
        done++;
        send_item(it, has_res, res);
        if (has_res) pending_finds.push_back(res);
      end
    end

    wait_quiet();
    if (pending_finds.size() != 0) note_mismatch("results still outstanding");
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/bakos_pkg.sv
rtl/core/bakos_ram.sv
rtl/core/bakos_ctrl.sv
rtl/core/bit_array_kth_one_select_top.sv
dv/testbench.sv
